### hw/rtl/dglp_pkg.sv
// Shared constants, record codes and types of the DIMACS graph line parser.
package dglp_pkg;

  // Fixed widths of the result fields.
  localparam int OUT_VERTEX_W = 24;
  localparam int OUT_COUNT_W  = 32;
  localparam int OUT_COST_W   = 32;

  // Default internal widths handed to the top level parameters.
  localparam int DEF_VERTEX_BITS     = 24;
  localparam int DEF_COST_BITS       = 32;
  localparam int DEF_EDGE_COUNT_BITS = 32;

  // Record kinds.
  localparam logic [1:0] KIND_PROBLEM = 2'd0;
  localparam logic [1:0] KIND_EDGE    = 2'd1;
  localparam logic [1:0] KIND_WARNING = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_EMPTY_LINE  = 4'd1;
  localparam logic [3:0] ST_EDGE_EARLY  = 4'd2;
  localparam logic [3:0] ST_EXTRA_EDGE  = 4'd3;
  localparam logic [3:0] ST_EDGE_SYNTAX = 4'd4;
  localparam logic [3:0] ST_PROB_REPEAT = 4'd5;
  localparam logic [3:0] ST_PROB_SYNTAX = 4'd6;
  localparam logic [3:0] ST_UNKNOWN     = 4'd7;
  localparam logic [3:0] ST_NO_PROBLEM  = 4'd8;
  localparam logic [3:0] ST_FEW_EDGES   = 4'd9;

  // Characters of the file format.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;

  // One result record as it leaves the block.
  typedef struct packed {
    logic [1:0]              record_kind;
    logic [3:0]              status_code;
    logic [OUT_VERTEX_W-1:0] src_vertex;
    logic [OUT_VERTEX_W-1:0] dst_vertex;
    logic [OUT_COST_W-1:0]   edge_cost;
    logic [OUT_VERTEX_W-1:0] vertex_total;
    logic [OUT_COUNT_W-1:0]  edge_total;
    logic [OUT_COST_W-1:0]   max_cost;
    logic [OUT_COST_W-1:0]   min_cost;
    logic                    final_record;
  } rec_t;

  // Records produced by one byte, handed from the parser to the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

### hw/rtl/dglp_chan_if.sv
// Valid/ready channel interfaces for the byte input and the record output.
interface dglp_in_if import dglp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_file;

  modport source (output valid, char_byte, end_of_file, input ready);
  modport sink   (input valid, char_byte, end_of_file, output ready);
endinterface

interface dglp_out_if import dglp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              record_kind;
  logic [3:0]              status_code;
  logic [OUT_VERTEX_W-1:0] src_vertex;
  logic [OUT_VERTEX_W-1:0] dst_vertex;
  logic [OUT_COST_W-1:0]   edge_cost;
  logic [OUT_VERTEX_W-1:0] vertex_total;
  logic [OUT_COUNT_W-1:0]  edge_total;
  logic [OUT_COST_W-1:0]   max_cost;
  logic [OUT_COST_W-1:0]   min_cost;
  logic                    final_record;

  modport source (output valid, record_kind, status_code, src_vertex, dst_vertex, edge_cost,
                  vertex_total, edge_total, max_cost, min_cost, final_record,
                  input ready);
  modport sink   (input valid, record_kind, status_code, src_vertex, dst_vertex, edge_cost,
                  vertex_total, edge_total, max_cost, min_cost, final_record,
                  output ready);
endinterface

### hw/rtl/dglp_outq.sv
// Two-entry record queue: takes up to two records per cycle, hands out one.
module dglp_outq import dglp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       pop,
  output rec_t       head,
  output logic       head_valid,
  output logic [1:0] room
);

  rec_t       q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt, cnt_left;

  assign head       = q0_r;
  assign head_valid = (cnt_r != 2'd0);
  assign cnt_left   = cnt_r - {1'b0, pop};
  assign room       = 2'd2 - cnt_left;

  always_comb begin
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_left + push.cnt;
    if (cnt_left == 2'd0) begin
      q0_nxt = push.rec0;
      q1_nxt = push.rec1;
    end else if (cnt_left == 2'd1) begin
      q1_nxt = push.rec0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

### hw/rtl/dglp_core.sv
// Line parser state and per-byte decode; produces up to two records per byte.
module dglp_core import dglp_pkg::*; #(
  parameter int VERTEX_BITS     = DEF_VERTEX_BITS,
  parameter int COST_BITS       = DEF_COST_BITS,
  parameter int EDGE_COUNT_BITS = DEF_EDGE_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  logic [7:0] char_byte,
  input  logic       end_of_file,
  input  logic       go,
  output push_t      push
);

  localparam int VB    = VERTEX_BITS;
  localparam int CB    = COST_BITS;
  localparam int EB    = EDGE_COUNT_BITS;
  localparam int ACC_W = (VB > CB) ? ((VB > EB) ? VB : EB) : ((CB > EB) ? CB : EB);

  localparam logic [2:0] LT_NONE    = 3'd0;
  localparam logic [2:0] LT_EDGE    = 3'd1;
  localparam logic [2:0] LT_PROB    = 3'd2;
  localparam logic [2:0] LT_COMMENT = 3'd3;
  localparam logic [2:0] LT_OTHER   = 3'd4;

  localparam logic [2:0] FP_VERT2 = 3'd2;
  localparam logic [2:0] FP_COST  = 3'd3;
  localparam logic [2:0] FP_PNUM  = 3'd4;
  localparam logic [2:0] FP_PEDGE = 3'd5;

  localparam logic [7:0] SP_TAG [4] = '{CH_SPACE, CH_S, CH_P, CH_SPACE};

  logic [2:0]       lt_r, lt_nxt, fp_r, fp_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             ds_r, ds_nxt, lf_r, lf_nxt, halt_r, halt_nxt;
  logic [VB-1:0]    hf_r, hf_nxt, ht_r, ht_nxt, dv_r, dv_nxt;
  logic [EB-1:0]    de_r, de_nxt, es_r, es_nxt;
  logic [CB-1:0]    ch_r, ch_nxt, cl_r, cl_nxt;

  logic             is_digit, is_nl, feed_do, fin_do, eof_do;
  logic [3:0]       dig;
  logic [ACC_W+3:0] acc_x10;
  logic             ovf_v, ovf_c, ovf_e;
  logic             fin_emit, fin_edge, fin_err, chk_emit;
  logic [1:0]       fin_kind;
  logic [3:0]       fin_stat, chk_stat;
  logic [CB-1:0]    cost_v;
  rec_t             rec_a, rec_b;

  assign is_digit = (char_byte >= CH_0) && (char_byte <= CH_9);
  assign dig      = is_digit ? 4'(char_byte - CH_0) : 4'd0;
  assign is_nl    = (char_byte == CH_NEWLINE);
  assign cost_v   = acc_r[CB-1:0];

  // Next decimal value and its range checks against each field width.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (ACC_W+4)'(dig);
  assign ovf_v   = (acc_x10 >> VB) != '0;
  assign ovf_c   = (acc_x10 >> CB) != '0;
  assign ovf_e   = (acc_x10 >> EB) != '0;

  assign feed_do = item_valid && !halt_r && !end_of_file && !is_nl;
  assign fin_do  = item_valid && !halt_r && (end_of_file ? (lt_r != LT_NONE) : is_nl);
  assign eof_do  = item_valid && !halt_r && end_of_file;

  always_comb begin
    lt_nxt   = lt_r;
    fp_nxt   = fp_r;
    acc_nxt  = acc_r;
    ds_nxt   = ds_r;
    lf_nxt   = lf_r;
    hf_nxt   = hf_r;
    ht_nxt   = ht_r;
    dv_nxt   = dv_r;
    de_nxt   = de_r;
    es_nxt   = es_r;
    ch_nxt   = ch_r;
    cl_nxt   = cl_r;
    halt_nxt = halt_r;
    fin_emit = 1'b0;
    fin_edge = 1'b0;
    fin_kind = KIND_WARNING;
    fin_stat = ST_OK;

    if (feed_do) begin
      priority if (lt_r == LT_NONE) begin
        fp_nxt  = 3'd0;
        acc_nxt = '0;
        ds_nxt  = 1'b0;
        lf_nxt  = 1'b0;
        lt_nxt  = (char_byte == CH_A) ? LT_EDGE :
                  (char_byte == CH_P) ? LT_PROB :
                  (char_byte == CH_C) ? LT_COMMENT : LT_OTHER;
      end else if (lf_r || lt_r == LT_COMMENT || lt_r == LT_OTHER) begin
        lf_nxt = lf_r;
      end else if (lt_r == LT_EDGE) begin
        priority if (fp_r == 3'd0) begin
          if (char_byte == CH_SPACE) fp_nxt = 3'd1;
          else lf_nxt = 1'b1;
        end else if (fp_r <= FP_VERT2) begin
          priority if (is_digit) begin
            if (ovf_v) begin
              lf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10[ACC_W-1:0];
              ds_nxt  = 1'b1;
            end
          end else if (char_byte == CH_SPACE) begin
            if (acc_r == '0 || acc_r > ACC_W'(dv_r)) begin
              lf_nxt = 1'b1;
            end else begin
              if (fp_r == FP_VERT2) ht_nxt = acc_r[VB-1:0] - 1'b1;
              else hf_nxt = acc_r[VB-1:0] - 1'b1;
              fp_nxt  = fp_r + 3'd1;
              acc_nxt = '0;
              ds_nxt  = 1'b0;
            end
          end else begin
            lf_nxt = 1'b1;
          end
        end else begin
          if (is_digit && !ovf_c) begin
            acc_nxt = acc_x10[ACC_W-1:0];
            ds_nxt  = 1'b1;
          end else begin
            lf_nxt = 1'b1;
          end
        end
      end else begin
        // Problem line: fixed " sp " tag, vertex count, then edge count.
        priority if (fp_r < FP_PNUM) begin
          if (char_byte == SP_TAG[fp_r[1:0]]) fp_nxt = fp_r + 3'd1;
          else lf_nxt = 1'b1;
        end else if (fp_r == FP_PNUM) begin
          priority if (is_digit) begin
            if (ovf_v) begin
              lf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10[ACC_W-1:0];
              ds_nxt  = 1'b1;
            end
          end else if (char_byte == CH_SPACE && acc_r != '0) begin
            hf_nxt  = acc_r[VB-1:0];
            fp_nxt  = FP_PEDGE;
            acc_nxt = '0;
            ds_nxt  = 1'b0;
          end else begin
            lf_nxt = 1'b1;
          end
        end else begin
          if (is_digit && !ovf_e) begin
            acc_nxt = acc_x10[ACC_W-1:0];
            ds_nxt  = 1'b1;
          end else begin
            lf_nxt = 1'b1;
          end
        end
      end
    end

    if (fin_do) begin
      unique case (lt_r)
        LT_NONE: begin
          fin_emit = 1'b1;
          fin_stat = ST_EMPTY_LINE;
        end
        LT_COMMENT: begin
          fin_emit = 1'b0;
        end
        LT_OTHER: begin
          fin_emit = 1'b1;
          fin_stat = ST_UNKNOWN;
        end
        LT_EDGE: begin
          fin_emit = 1'b1;
          priority if (dv_r == '0) begin
            fin_kind = KIND_ERROR;
            fin_stat = ST_EDGE_EARLY;
          end else if (es_r >= de_r) begin
            fin_stat = ST_EXTRA_EDGE;
          end else if (lf_r || fp_r != FP_COST || !ds_r) begin
            fin_kind = KIND_ERROR;
            fin_stat = ST_EDGE_SYNTAX;
          end else begin
            fin_kind = KIND_EDGE;
            fin_edge = 1'b1;
            es_nxt   = es_r + 1'b1;
            if (cost_v > ch_r) ch_nxt = cost_v;
            if (cost_v < cl_r) cl_nxt = cost_v;
          end
        end
        default: begin
          fin_emit = 1'b1;
          priority if (dv_r != '0) begin
            fin_stat = ST_PROB_REPEAT;
          end else if (lf_r || fp_r != FP_PEDGE || !ds_r || acc_r == '0) begin
            fin_kind = KIND_ERROR;
            fin_stat = ST_PROB_SYNTAX;
          end else begin
            fin_kind = KIND_PROBLEM;
            dv_nxt   = hf_r;
            de_nxt   = acc_r[EB-1:0];
          end
        end
      endcase
      lt_nxt  = LT_NONE;
      fp_nxt  = 3'd0;
      acc_nxt = '0;
      ds_nxt  = 1'b0;
      lf_nxt  = 1'b0;
    end

    fin_err  = fin_emit && (fin_kind == KIND_ERROR);
    chk_emit = eof_do && !fin_err && (dv_nxt == '0 || es_nxt < de_nxt);
    chk_stat = (dv_nxt == '0) ? ST_NO_PROBLEM : ST_FEW_EDGES;
    if (fin_err || eof_do) halt_nxt = 1'b1;
  end

  // Records carry the totals and cost extremes as they stand after this byte.
  always_comb begin
    rec_a.record_kind  = fin_kind;
    rec_a.status_code  = fin_stat;
    rec_a.src_vertex   = fin_edge ? OUT_VERTEX_W'(hf_r) : '0;
    rec_a.dst_vertex   = fin_edge ? OUT_VERTEX_W'(ht_r) : '0;
    rec_a.edge_cost    = fin_edge ? OUT_COST_W'(cost_v) : '0;
    rec_a.vertex_total = OUT_VERTEX_W'(dv_nxt);
    rec_a.edge_total   = OUT_COUNT_W'(de_nxt);
    rec_a.max_cost     = OUT_COST_W'(ch_nxt);
    rec_a.min_cost     = OUT_COST_W'(cl_nxt);
    rec_a.final_record = !chk_emit;

    rec_b              = rec_a;
    rec_b.record_kind  = KIND_ERROR;
    rec_b.status_code  = chk_stat;
    rec_b.src_vertex   = '0;
    rec_b.dst_vertex   = '0;
    rec_b.edge_cost    = '0;
    rec_b.final_record = 1'b1;

    push.cnt  = {1'b0, fin_emit} + {1'b0, chk_emit};
    push.rec0 = fin_emit ? rec_a : rec_b;
    push.rec1 = rec_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r   <= LT_NONE;
      fp_r   <= 3'd0;
      acc_r  <= '0;
      ds_r   <= 1'b0;
      lf_r   <= 1'b0;
      hf_r   <= '0;
      ht_r   <= '0;
      dv_r   <= '0;
      de_r   <= '0;
      es_r   <= '0;
      ch_r   <= '0;
      cl_r   <= '1;
      halt_r <= 1'b0;
    end else if (go) begin
      lt_r   <= lt_nxt;
      fp_r   <= fp_nxt;
      acc_r  <= acc_nxt;
      ds_r   <= ds_nxt;
      lf_r   <= lf_nxt;
      hf_r   <= hf_nxt;
      ht_r   <= ht_nxt;
      dv_r   <= dv_nxt;
      de_r   <= de_nxt;
      es_r   <= es_nxt;
      ch_r   <= ch_nxt;
      cl_r   <= cl_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

### hw/rtl/dimacs_graph_line_parser_unit.sv
// Top level of the DIMACS shortest-path graph line parser.
//
//   Channel   Direction  Beat carries
//   in_bus    in         one file byte (char_byte) or an end-of-file mark
//   out_bus   out        one problem, edge, warning or error record
//
// A byte is taken into an input register, decoded there against the line state,
// and its records land in a two-entry output queue. With the output side ready
// the unit takes one byte every cycle; the first record of a byte passes the
// input register and then the queue register before it shows on the output port.
// The queue depth sets the stall behavior: a byte waits in the input register
// only while its records do not fit in the queue.
// The synchronous active-low reset returns the parser to the start of a file.
// After an error record or end of file, bytes are still taken but give nothing.
module dimacs_graph_line_parser_unit import dglp_pkg::*; #(
  parameter int VERTEX_BITS     = DEF_VERTEX_BITS,
  parameter int COST_BITS       = DEF_COST_BITS,
  parameter int EDGE_COUNT_BITS = DEF_EDGE_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  dglp_in_if.sink    in_bus,
  dglp_out_if.source out_bus
);

  // Input register: holds the byte being decoded.
  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eof_r;

  logic       in_take, go, pop, head_valid;
  logic [1:0] room;
  push_t      push;
  rec_t       head;

  // The byte leaves the input register once all its records fit in the queue,
  // counting the slot that the output side frees in this cycle.
  assign go        = s1_v_r && (push.cnt <= room);
  assign in_take   = in_bus.valid && in_bus.ready;
  assign s1_v_nxt  = in_take || (s1_v_r && !go);
  assign in_bus.ready = !s1_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_bus.char_byte;
      s1_eof_r  <= in_bus.end_of_file;
    end
  end

  dglp_core #(
    .VERTEX_BITS     (VERTEX_BITS),
    .COST_BITS       (COST_BITS),
    .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (s1_v_r),
    .char_byte   (s1_byte_r),
    .end_of_file (s1_eof_r),
    .go          (go),
    .push        (push)
  );

  // Records reach the queue only when their byte actually moves on.
  push_t push_q;
  always_comb begin
    push_q     = push;
    push_q.cnt = go ? push.cnt : 2'd0;
  end

  assign pop = head_valid && out_bus.ready;

  dglp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_q),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign out_bus.valid        = head_valid;
  assign out_bus.record_kind  = head.record_kind;
  assign out_bus.status_code  = head.status_code;
  assign out_bus.src_vertex   = head.src_vertex;
  assign out_bus.dst_vertex   = head.dst_vertex;
  assign out_bus.edge_cost    = head.edge_cost;
  assign out_bus.vertex_total = head.vertex_total;
  assign out_bus.edge_total   = head.edge_total;
  assign out_bus.max_cost     = head.max_cost;
  assign out_bus.min_cost     = head.min_cost;
  assign out_bus.final_record = head.final_record;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the DIMACS graph line parser: random .gr files, predicted records.
`timescale 1ns / 100ps

module testbench;
  import dglp_pkg::*;

  // Largest values that the decimal fields of a line may hold.
  localparam logic [63:0] VERTEX_MAX = (64'd1 << DEF_VERTEX_BITS) - 64'd1;
  localparam logic [63:0] COST_MAX   = (64'd1 << DEF_COST_BITS) - 64'd1;
  localparam logic [63:0] COUNT_MAX  = (64'd1 << DEF_EDGE_COUNT_BITS) - 64'd1;

  // Cycles without any beat on either channel before the run is declared hung,
  // and the quiet time after the last record that catches stray records.
  localparam int unsigned IDLE_LIMIT   = 400;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Classification of the line that is being parsed.
  typedef enum logic [2:0] {
    LINE_NONE,
    LINE_EDGE,
    LINE_PROB,
    LINE_COMMENT,
    LINE_OTHER
  } line_kind_e;

  // How a generated file ends. Since reset comes only once, the ending is the
  // one place where an error record may appear.
  typedef enum logic [2:0] {
    END_CLEAN,
    END_OPEN_TEXT,
    END_OPEN_EDGE,
    END_FEW_EDGES,
    END_BAD_EDGE
  } file_end_e;

  // One input beat: a file byte, or an end-of-file mark when eof is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } file_beat_t;

  // The scoreboard keeps its own copy of the parser state. Each accepted byte
  // is run through it, and the records that byte must cause are queued in
  // order; every record from the block is checked against the oldest one.
  class gr_parse_scoreboard;
    line_kind_e  line_kind;
    logic [2:0]  field_pos;
    logic [63:0] acc;
    logic        digit_seen;
    logic        line_fault;
    logic [23:0] held_from;
    logic [23:0] held_to;
    logic [23:0] vertex_count;
    logic [31:0] edge_count;
    logic [31:0] edges_accepted;
    logic [31:0] cost_high;
    logic [31:0] cost_low;
    logic        halted;
    rec_t        pending_records[$];
    int unsigned error_count;

    function new();
      clear_line();
      held_from      = '0;
      held_to        = '0;
      vertex_count   = '0;
      edge_count     = '0;
      edges_accepted = '0;
      cost_high      = '0;
      cost_low       = '1;
      halted         = 1'b0;
      error_count    = 0;
    endfunction

    function void clear_line();
      line_kind  = LINE_NONE;
      field_pos  = '0;
      acc        = '0;
      digit_seen = 1'b0;
      line_fault = 1'b0;
    endfunction

    // The four characters between 'p' and the vertex count.
    function logic [7:0] problem_tag_char(logic [2:0] pos);
      case (pos)
        3'd1: return CH_S;
        3'd2: return CH_P;
        default: return CH_SPACE;
      endcase
    endfunction

    // A digit that would push the field past its limit spoils the whole line.
    function void add_digit(logic [63:0] d, logic [63:0] limit);
      if (acc > (limit - d) / 64'd10) begin
        line_fault = 1'b1;
      end else begin
        acc        = acc * 64'd10 + d;
        digit_seen = 1'b1;
      end
    endfunction

    function void emit(logic [1:0] kind, logic [3:0] status, logic [23:0] from_v,
                       logic [23:0] to_v, logic [31:0] cost);
      rec_t r;
      r.record_kind  = kind;
      r.status_code  = status;
      r.src_vertex   = from_v;
      r.dst_vertex   = to_v;
      r.edge_cost    = cost;
      r.vertex_total = vertex_count;
      r.edge_total   = edge_count;
      r.max_cost     = cost_high;
      r.min_cost     = cost_low;
      r.final_record = 1'b0;
      pending_records.push_back(r);
      if (kind == KIND_ERROR) begin
        halted = 1'b1;
      end
    endfunction

    function void feed_byte(logic [7:0] ch);
      logic        is_digit;
      logic [63:0] d;
      is_digit = (ch >= CH_0) && (ch <= CH_9);
      d = is_digit ? 64'(ch - CH_0) : 64'd0;
      if (line_kind == LINE_NONE) begin
        clear_line();
        case (ch)
          CH_A: line_kind = LINE_EDGE;
          CH_P: line_kind = LINE_PROB;
          CH_C: line_kind = LINE_COMMENT;
          default: line_kind = LINE_OTHER;
        endcase
        return;
      end
      if (line_fault || line_kind == LINE_COMMENT || line_kind == LINE_OTHER) begin
        return;
      end
      if (line_kind == LINE_EDGE) begin
        if (field_pos == 3'd0) begin
          if (ch == CH_SPACE) field_pos = 3'd1;
          else line_fault = 1'b1;
        end else if (field_pos <= 3'd2) begin
          if (is_digit) begin
            add_digit(d, VERTEX_MAX);
          end else if (ch == CH_SPACE) begin
            // Vertices are one-based in the file and must lie within the declared count.
            if (acc == 64'd0 || acc > 64'(vertex_count)) begin
              line_fault = 1'b1;
            end else begin
              if (field_pos == 3'd1) held_from = 24'(acc - 64'd1);
              else held_to = 24'(acc - 64'd1);
              field_pos  = field_pos + 3'd1;
              acc        = '0;
              digit_seen = 1'b0;
            end
          end else begin
            line_fault = 1'b1;
          end
        end else begin
          if (is_digit) add_digit(d, COST_MAX);
          else line_fault = 1'b1;
        end
      end else if (field_pos < 3'd4) begin
        if (ch == problem_tag_char(field_pos)) field_pos = field_pos + 3'd1;
        else line_fault = 1'b1;
      end else if (field_pos == 3'd4) begin
        if (is_digit) begin
          add_digit(d, VERTEX_MAX);
        end else if (ch == CH_SPACE && acc != 64'd0) begin
          held_from  = 24'(acc);
          field_pos  = 3'd5;
          acc        = '0;
          digit_seen = 1'b0;
        end else begin
          line_fault = 1'b1;
        end
      end else begin
        if (is_digit) add_digit(d, COUNT_MAX);
        else line_fault = 1'b1;
      end
    endfunction

    function void finish_line();
      case (line_kind)
        LINE_NONE:    emit(KIND_WARNING, ST_EMPTY_LINE, '0, '0, '0);
        LINE_COMMENT: ;
        LINE_OTHER:   emit(KIND_WARNING, ST_UNKNOWN, '0, '0, '0);
        LINE_EDGE: begin
          // Surplus edges are dropped before their syntax is even looked at.
          if (vertex_count == '0) begin
            emit(KIND_ERROR, ST_EDGE_EARLY, '0, '0, '0);
          end else if (edges_accepted >= edge_count) begin
            emit(KIND_WARNING, ST_EXTRA_EDGE, '0, '0, '0);
          end else if (line_fault || field_pos != 3'd3 || !digit_seen) begin
            emit(KIND_ERROR, ST_EDGE_SYNTAX, '0, '0, '0);
          end else begin
            if (acc[31:0] > cost_high) cost_high = acc[31:0];
            if (acc[31:0] < cost_low) cost_low = acc[31:0];
            edges_accepted = edges_accepted + 32'd1;
            emit(KIND_EDGE, ST_OK, held_from, held_to, acc[31:0]);
          end
        end
        default: begin
          if (vertex_count != '0) begin
            emit(KIND_WARNING, ST_PROB_REPEAT, '0, '0, '0);
          end else if (line_fault || field_pos != 3'd5 || !digit_seen || acc == 64'd0) begin
            emit(KIND_ERROR, ST_PROB_SYNTAX, '0, '0, '0);
          end else begin
            vertex_count = held_from;
            edge_count   = acc[31:0];
            emit(KIND_PROBLEM, ST_OK, '0, '0, '0);
          end
        end
      endcase
      clear_line();
    endfunction

    // Called for every accepted input beat.
    function void note_byte(logic [7:0] ch, logic eof);
      int unsigned queued;
      queued = pending_records.size();
      if (halted) begin
        return;
      end
      if (eof) begin
        if (line_kind != LINE_NONE) finish_line();
        if (!halted) begin
          if (vertex_count == '0) emit(KIND_ERROR, ST_NO_PROBLEM, '0, '0, '0);
          else if (edges_accepted < edge_count) emit(KIND_ERROR, ST_FEW_EDGES, '0, '0, '0);
        end
        halted = 1'b1;
      end else if (ch == CH_NEWLINE) begin
        finish_line();
      end else begin
        feed_byte(ch);
      end
      if (pending_records.size() > queued) begin
        pending_records[pending_records.size() - 1].final_record = 1'b1;
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    // Called for every accepted output beat.
    function void check_record(rec_t got);
      rec_t want;
      if (pending_records.size() == 0) begin
        $display("%0t: record expected none got kind %0h status %0h", $time,
                 got.record_kind, got.status_code);
        error_count++;
        return;
      end
      want = pending_records.pop_front();
      check_field("record_kind", want.record_kind, got.record_kind);
      check_field("status_code", want.status_code, got.status_code);
      check_field("src_vertex", want.src_vertex, got.src_vertex);
      check_field("dst_vertex", want.dst_vertex, got.dst_vertex);
      check_field("edge_cost", want.edge_cost, got.edge_cost);
      check_field("vertex_total", want.vertex_total, got.vertex_total);
      check_field("edge_total", want.edge_total, got.edge_total);
      check_field("max_cost", want.max_cost, got.max_cost);
      check_field("min_cost", want.min_cost, got.min_cost);
      check_field("final_record", want.final_record, got.final_record);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned idle_cycles = 0;

  dglp_in_if  in_ch ();
  dglp_out_if out_ch ();

  dimacs_graph_line_parser_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  gr_parse_scoreboard parse_board;

  // The whole file is generated before the run, one beat per entry. The
  // declared vertex and edge counts steer which edge lines are well formed.
  file_beat_t  file_stream[$];
  logic [63:0] file_vertices;
  logic [63:0] file_edges;

  always #2 clk = ~clk;

  function automatic void put_byte(logic [7:0] ch);
    file_stream.push_back({ch, 1'b0});
  endfunction

  // Decimal text of v, with some leading zeros now and then.
  function automatic void put_number(logic [63:0] v);
    logic [7:0] digits[$];
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) put_byte(CH_0);
    end
    do begin
      digits.push_front(CH_0 + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digits[i]) put_byte(digits[i]);
  endfunction

  // Arbitrary bytes other than newline, so that the line stays open.
  function automatic void put_noise(int unsigned count);
    logic [7:0] ch;
    repeat (count) begin
      do begin
        ch = 8'($urandom);
      end while (ch == CH_NEWLINE);
      put_byte(ch);
    end
  endfunction

  function automatic logic [63:0] pick_vertex();
    case ($urandom_range(0, 3))
      0: return 64'd1;
      1: return file_vertices;
      2: return 64'($urandom_range(1, 32'(file_vertices)));
      default: return 64'($urandom_range(1, (file_vertices < 20) ? 32'(file_vertices) : 20));
    endcase
  endfunction

  function automatic logic [63:0] pick_cost();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return COST_MAX;
      2: return 64'($urandom);
      default: return 64'($urandom_range(0, 100));
    endcase
  endfunction

  // The three fields of an edge line, each behind its separating space.
  function automatic void put_edge_fields(logic [63:0] u, logic [63:0] v, logic [63:0] w);
    put_byte(CH_SPACE);
    put_number(u);
    put_byte(CH_SPACE);
    put_number(v);
    put_byte(CH_SPACE);
    put_number(w);
  endfunction

  function automatic void put_good_edge();
    put_byte(CH_A);
    put_edge_fields(pick_vertex(), pick_vertex(), pick_cost());
  endfunction

  // An edge line that breaks one rule: a vertex of zero or above the count, a
  // number too wide for its field, stray or missing fields, or plain noise.
  function automatic void put_bad_edge();
    put_byte(CH_A);
    case ($urandom_range(0, 7))
      0: put_edge_fields(pick_vertex(), 64'd0, pick_cost());
      1: put_edge_fields(file_vertices + 64'($urandom_range(1, 1000)), pick_vertex(), pick_cost());
      2: put_edge_fields(pick_vertex(), VERTEX_MAX + 64'($urandom_range(1, 99999)), pick_cost());
      3: put_edge_fields(pick_vertex(), pick_vertex(), COST_MAX + 64'($urandom_range(1, 999)));
      4: begin
        put_edge_fields(pick_vertex(), pick_vertex(), pick_cost());
        put_byte(CH_SPACE);
      end
      5: begin
        put_byte(CH_SPACE);
        put_number(pick_vertex());
        put_byte(CH_SPACE);
        put_number(pick_vertex());
        if ($urandom_range(0, 1) == 1) put_byte(CH_SPACE);
      end
      6: begin
        put_byte(CH_SPACE);
        put_edge_fields(pick_vertex(), pick_vertex(), pick_cost());
      end
      default: put_noise($urandom_range(0, 12));
    endcase
  endfunction

  function automatic void put_comment();
    put_byte(CH_C);
    put_noise($urandom_range(0, 12));
  endfunction

  function automatic void put_unknown();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom);
    end while (ch == CH_A || ch == CH_C || ch == CH_P || ch == CH_NEWLINE);
    put_byte(ch);
    put_noise($urandom_range(0, 8));
  endfunction

  function automatic void put_problem(logic [63:0] n, logic [63:0] m);
    put_byte(CH_P);
    put_byte(CH_SPACE);
    put_byte(CH_S);
    put_byte(CH_P);
    put_byte(CH_SPACE);
    put_number(n);
    put_byte(CH_SPACE);
    put_number(m);
  endfunction

  // Problem lines after the first are only warned about, well formed or not.
  function automatic void put_repeat_problem();
    if ($urandom_range(0, 1) == 1) begin
      put_problem(64'($urandom_range(0, 99999)), 64'($urandom));
    end else begin
      put_byte(CH_P);
      put_noise($urandom_range(0, 10));
    end
  endfunction

  function automatic void build_file();
    file_end_e   ending;
    logic [63:0] budget;
    logic [63:0] edges_sent;
    int unsigned pick;
    bit          whole_file;
    case ($urandom_range(0, 3))
      0: file_vertices = VERTEX_MAX;
      1: file_vertices = 64'($urandom_range(1, 9));
      2: file_vertices = 64'($urandom_range(10, 1000));
      default: file_vertices = 64'($urandom_range(1, 32'(VERTEX_MAX)));
    endcase
    // Now and then the declared edge count is the largest there is, so the
    // file can only end short of it.
    if ($urandom_range(0, 5) == 0) begin
      file_edges = COUNT_MAX;
      ending = file_end_e'($urandom_range(int'(END_OPEN_EDGE), int'(END_BAD_EDGE)));
      budget = 64'($urandom_range(40, 60));
    end else begin
      file_edges = 64'($urandom_range(40, 60));
      ending = file_end_e'($urandom_range(int'(END_CLEAN), int'(END_BAD_EDGE)));
      case (ending)
        END_CLEAN, END_OPEN_TEXT: budget = file_edges;
        END_OPEN_EDGE: budget = file_edges - 64'd2;
        default: budget = file_edges - 64'($urandom_range(1, 3));
      endcase
    end
    whole_file = (ending == END_CLEAN || ending == END_OPEN_TEXT);

    // Opening lines: an empty line, an unknown line, a comment, then the
    // problem line and an edge each way between the first and the last vertex, one at the highest cost and one at zero.
    put_byte(CH_NEWLINE);
    put_byte(8'hFF);
    put_byte(CH_NEWLINE);
    put_byte(CH_C);
    put_byte(8'h00);
    put_byte(8'h80);
    put_byte(CH_NEWLINE);
    put_problem(file_vertices, file_edges);
    put_byte(CH_NEWLINE);
    put_byte(CH_A);
    put_edge_fields(64'd1, file_vertices, COST_MAX);
    put_byte(CH_NEWLINE);
    put_byte(CH_A);
    put_edge_fields(file_vertices, 64'd1, 64'd0);
    put_byte(CH_NEWLINE);
    edges_sent = 64'd2;

    // Body: mostly valid edges, mixed with comments, empty and unknown lines
    // and repeated problem lines. Once the declared edges are all in, edge
    // lines of any shape are surplus and only draw a warning.
    while (edges_sent < budget || (whole_file && file_stream.size() < 1050)) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        if (edges_sent < budget) begin
          put_good_edge();
          edges_sent = edges_sent + 64'd1;
        end else if ($urandom_range(0, 1) == 1) begin
          put_good_edge();
        end else begin
          put_bad_edge();
        end
      end else if (pick < 74) begin
        put_comment();
      end else if (pick < 88) begin
        if (pick >= 80) put_unknown();
      end else begin
        put_repeat_problem();
      end
      put_byte(CH_NEWLINE);
    end

    case (ending)
      END_OPEN_TEXT: begin
        case ($urandom_range(0, 3))
          0: put_comment();
          1: put_unknown();
          2: put_repeat_problem();
          default: put_bad_edge();
        endcase
      end
      END_OPEN_EDGE: put_good_edge();
      END_BAD_EDGE: begin
        put_bad_edge();
        put_byte(CH_NEWLINE);
      end
      default: ;
    endcase
    if (ending != END_BAD_EDGE) begin
      file_stream.push_back({8'($urandom), 1'b1});
    end
    // Beats after the block has stopped must be taken and give nothing.
    repeat ($urandom_range(8, 24)) begin
      file_stream.push_back({8'($urandom), 1'($urandom_range(0, 1))});
    end
  endfunction

  // Byte side. Each beat may first be held back with valid low, except inside bursts
  // that switch on and off at random and send back to back.
  task automatic send_file();
    int unsigned gap;
    bit          burst;
    burst = 1'b0;
    foreach (file_stream[i]) begin
      if ($urandom_range(0, 31) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.char_byte   <= file_stream[i].ch;
      in_ch.end_of_file <= file_stream[i].eof;
      do begin
        @(posedge clk);
      end while (!in_ch.ready);
      parse_board.note_byte(file_stream[i].ch, file_stream[i].eof);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Record side. Ready may drop before each beat, with the
  // same kind of stall-free bursts as the byte side.
  task automatic take_records();
    int unsigned gap;
    bit          burst;
    rec_t        got;
    burst = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      do begin
        @(posedge clk);
      end while (!out_ch.valid);
      got.record_kind  = out_ch.record_kind;
      got.status_code  = out_ch.status_code;
      got.src_vertex   = out_ch.src_vertex;
      got.dst_vertex   = out_ch.dst_vertex;
      got.edge_cost    = out_ch.edge_cost;
      got.vertex_total = out_ch.vertex_total;
      got.edge_total   = out_ch.edge_total;
      got.max_cost     = out_ch.max_cost;
      got.min_cost     = out_ch.min_cost;
      got.final_record = out_ch.final_record;
      parse_board.check_record(got);
    end
  endtask

  // Watchdog: any beat on either side restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("dimacs_graph_line_parser_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    parse_board = new();
    in_ch.valid       <= 1'b0;
    in_ch.char_byte   <= '0;
    in_ch.end_of_file <= 1'b0;
    out_ch.ready      <= 1'b1;
    rst_n             <= 1'b0;
    build_file();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_records();
    join_none
    send_file();
    // Let every predicted record arrive, then stay a while to catch extras.
    while (parse_board.pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parse_board.error_count == 0) begin
      $display("dimacs_graph_line_parser_unit: match");
    end else begin
      $display("dimacs_graph_line_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
